>>> rtl/core/ese_pkg.sv
// ----------------------------------------------------------------------------
// ese_pkg
// Shared types, constants and helpers of the encoder speed estimator.
// ----------------------------------------------------------------------------
package ese_pkg;

    localparam int POS_W      = 12;
    localparam int POS_RANGE  = 1 << POS_W;
    localparam int STEP_W     = POS_W + 1;
    localparam int TS_W       = 64;
    localparam int RPM_W      = 32;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd1;

    localparam logic [CFG_W-1:0] WIN_LEN_RESET = 7'd40;

    // rpm_q8 = step * 60e9 * 256 / POS_RANGE / elapsed
    localparam logic [63:0] RPM_SCALE_64 =
        (64'd60 * 64'd1000000000 * 64'd256) / 64'(POS_RANGE);
    localparam logic [31:0] RPM_SCALE = RPM_SCALE_64[31:0];

    localparam logic [RPM_W-1:0] RPM_MAX = 32'h7FFF_FFFF;
    localparam logic [RPM_W-1:0] RPM_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVICT,
        ST_INSERT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUTPUT
    } ese_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV,
        DV_FIX
    } dv_state_t;

    typedef struct packed {
        logic evict;
        logic insert;
    } win_ctrl_t;

    // shortest signed wrap-around step; half-turn tie points against the move
    function automatic logic signed [STEP_W-1:0] shortest_step(
        input logic [POS_W-1:0] now_pos,
        input logic [POS_W-1:0] before_pos
    );
        logic signed [STEP_W-1:0] d;
        logic signed [STEP_W-1:0] a_full;
        logic [STEP_W-1:0]        a;
        logic [STEP_W-1:0]        wrap;
        logic signed [STEP_W-1:0] res;
        d      = signed'({1'b0, now_pos}) - signed'({1'b0, before_pos});
        a_full = d[STEP_W-1] ? -d : d;
        a      = {1'b0, a_full[POS_W-1:0]};
        wrap   = STEP_W'(POS_RANGE) - a;
        if (a < wrap)
        begin
            res = d;
        end
        else if (before_pos < now_pos)
        begin
            res = -signed'(wrap);
        end
        else
        begin
            res = signed'(wrap);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/encoder_speed_estimator.sv
// ----------------------------------------------------------------------------
// encoder_speed_estimator
// Signed RPM (Q23.8) from absolute encoder position deltas and timestamps,
// single-step or averaged over a sliding window.
// ----------------------------------------------------------------------------
//  channel  | direction | transfer carries
//  s_axis   | in        | position, timestamp_ns
//  m_axis   | out       | rpm_value, saturated
//  cfg      | in        | average_enable (index 0), window_length (index 1)
//
//  First item after reset: primes state, no output.
//  Other items: E window evictions, then a serial divide of NUM_W = SUM_W + 32
//  quotient bits (52 at depth 64), one quotient bit per cycle. E is one per item
//  once the window is full, more after window_length shrinks.
//  rst_n clears control state; the window memory is not cleared.
//  A pending result waits in the output register; the next item is taken
//  meanwhile, and only the final load stalls on m_tready.
// ----------------------------------------------------------------------------
module encoder_speed_estimator
    import ese_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] position, [75:12] timestamp_ns
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] rpm_value, [32] saturated
);

    localparam int SUM_W = STEP_W + $clog2(WINDOW_DEPTH + 1);

    ese_state_t              state_reg;
    ese_state_t              state_next;
    logic                    avg_en_reg;
    logic [CFG_W-1:0]        win_len_reg;
    logic                    primed_reg;
    logic [POS_W-1:0]        last_pos_reg;
    logic [TS_W-1:0]         last_ts_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic [TS_W-1:0]         elapsed_reg;
    logic                    m_valid_reg;
    logic [RPM_W-1:0]        rpm_reg;
    logic                    sat_reg;

    logic [POS_W-1:0]        in_pos;
    logic [TS_W-1:0]         in_ts;
    logic                    in_xfer;
    logic                    out_load;
    logic                    div_start;
    win_ctrl_t               win_ctrl;
    logic                    need_evict;
    logic signed [SUM_W-1:0] step_sum;
    logic [TS_W-1:0]         delta_sum;
    logic signed [SUM_W-1:0] div_value;
    logic [TS_W-1:0]         div_den;
    logic                    div_done;
    logic [RPM_W-1:0]        div_rpm;
    logic                    div_sat;

    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_ts   = s_tdata[POS_W+TS_W-1:POS_W];
    assign in_xfer = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && primed_reg)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = need_evict ? ST_EVICT : ST_INSERT;
            end
            ST_EVICT:
            begin
                state_next = ST_CHECK;
            end
            ST_INSERT:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        win_ctrl.evict  = (state_reg == ST_EVICT);
        win_ctrl.insert = (state_reg == ST_INSERT);
        div_start       = (state_reg == ST_DIV_START);
        out_load        = (state_reg == ST_OUTPUT) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            avg_en_reg  <= 1'b0;
            win_len_reg <= WIN_LEN_RESET;
            primed_reg  <= 1'b0;
            last_pos_reg <= '0;
            last_ts_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_AVERAGE_ENABLE: avg_en_reg  <= cfg_data[0];
                    REG_WINDOW_LENGTH:  win_len_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_xfer)
            begin
                primed_reg   <= 1'b1;
                last_pos_reg <= in_pos;
                last_ts_reg  <= in_ts;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            step_reg    <= shortest_step(in_pos, last_pos_reg);
            elapsed_reg <= in_ts - last_ts_reg;
        end
        if (out_load)
        begin
            rpm_reg <= div_rpm;
            sat_reg <= div_sat;
        end
    end

    assign div_value = avg_en_reg ? step_sum : SUM_W'(step_reg);
    assign div_den   = avg_en_reg ? delta_sum : elapsed_reg;

    ese_window #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_len    (win_len_reg),
        .ctrl       (win_ctrl),
        .step_in    (step_reg),
        .delta_in   (elapsed_reg),
        .need_evict (need_evict),
        .step_sum   (step_sum),
        .delta_sum  (delta_sum)
    );

    ese_divider #(
        .VAL_W (SUM_W)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .value   (div_value),
        .divisor (div_den),
        .done    (div_done),
        .rpm     (div_rpm),
        .sat     (div_sat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RPM_W - 1){1'b0}}, sat_reg, rpm_reg};

endmodule

>>> rtl/core/ese_window.sv
// ----------------------------------------------------------------------------
// ese_window
// Sliding window of recent steps and time deltas with running sums.
// ----------------------------------------------------------------------------
module ese_window
    import ese_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int SUM_W = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CFG_W-1:0]        win_len,
    input  win_ctrl_t               ctrl,
    input  logic signed [STEP_W-1:0] step_in,
    input  logic [TS_W-1:0]         delta_in,
    output logic                    need_evict,
    output logic signed [SUM_W-1:0] step_sum,
    output logic [TS_W-1:0]         delta_sum
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int LEN_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int OLD_W   = FILL_W + 1;
    localparam int ENTRY_W = TS_W + STEP_W;

    logic [ENTRY_W-1:0]      win_mem [0:DEPTH-1];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic signed [SUM_W-1:0] step_sum_reg;
    logic [TS_W-1:0]         delta_sum_reg;

    logic [LEN_W-1:0]        len_ext;
    logic [LEN_W-1:0]        len_eff;
    logic [OLD_W-1:0]        old_raw;
    logic [OLD_W-1:0]        old_wrap;
    logic [IDX_W-1:0]        old_idx;
    logic signed [SUM_W-1:0] rd_step_ext;
    logic signed [SUM_W-1:0] in_step_ext;

    always_comb
    begin
        len_ext = LEN_W'(win_len);
        if (len_ext == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_ext > LEN_W'(DEPTH))
        begin
            len_eff = LEN_W'(DEPTH);
        end
        else
        begin
            len_eff = len_ext;
        end
    end

    assign need_evict = LEN_W'(fill_reg) >= len_eff;

    // oldest entry sits fill slots behind the write slot
    always_comb
    begin
        old_raw = OLD_W'(slot_reg) + OLD_W'(DEPTH) - OLD_W'(fill_reg);
        if (old_raw >= OLD_W'(DEPTH))
        begin
            old_wrap = old_raw - OLD_W'(DEPTH);
        end
        else
        begin
            old_wrap = old_raw;
        end
        old_idx = old_wrap[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            win_mem[slot_reg] <= {delta_in, step_in};
        end
        rd_data_reg <= win_mem[old_idx];
    end

    assign rd_step_ext = SUM_W'(signed'(rd_data_reg[STEP_W-1:0]));
    assign in_step_ext = SUM_W'(step_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            slot_reg      <= '0;
            step_sum_reg  <= '0;
            delta_sum_reg <= '0;
        end
        else if (ctrl.evict)
        begin
            fill_reg      <= fill_reg - 1'b1;
            step_sum_reg  <= step_sum_reg - rd_step_ext;
            delta_sum_reg <= delta_sum_reg - rd_data_reg[ENTRY_W-1:STEP_W];
        end
        else if (ctrl.insert)
        begin
            fill_reg      <= fill_reg + 1'b1;
            step_sum_reg  <= step_sum_reg + in_step_ext;
            delta_sum_reg <= delta_sum_reg + delta_in;
            if (slot_reg == IDX_W'(DEPTH - 1))
            begin
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    assign step_sum  = step_sum_reg;
    assign delta_sum = delta_sum_reg;

endmodule

>>> rtl/core/ese_divider.sv
// ----------------------------------------------------------------------------
// ese_divider
// Scales a signed step count and divides it by elapsed time, one quotient
// bit per cycle, with saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module ese_divider
    import ese_pkg::*;
#(
    parameter int VAL_W = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] value,
    input  logic [TS_W-1:0]         divisor,
    output logic                    done,
    output logic [RPM_W-1:0]        rpm,
    output logic                    sat
);

    localparam int NUM_W = VAL_W + 32;
    localparam int CNT_W = $clog2(NUM_W);

    dv_state_t          state_reg;
    dv_state_t          state_next;
    logic               neg_reg;
    logic [VAL_W-1:0]   mag_reg;
    logic [TS_W-1:0]    den_reg;
    logic               den_zero_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [TS_W-1:0]    rem_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [VAL_W-1:0]   value_abs;
    logic [NUM_W-1:0]   product;
    logic [TS_W:0]      trial;
    logic [TS_W+1:0]    diff;
    logic               ge;
    logic               big;
    logic               over;
    logic [RPM_W-1:0]   q32;
    logic [RPM_W-1:0]   mag_out;

    assign value_abs = value[VAL_W-1] ? VAL_W'(-value) : VAL_W'(value);
    assign product   = mag_reg * RPM_SCALE;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = !diff[TS_W+1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_MUL;
                end
            end
            DV_MUL:
            begin
                state_next = DV_DIV;
            end
            DV_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DV_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    neg_reg      <= value[VAL_W-1];
                    mag_reg      <= value_abs;
                    den_reg      <= divisor;
                    den_zero_reg <= (divisor == '0);
                end
            end
            DV_MUL:
            begin
                quo_reg <= product;
                rem_reg <= '0;
            end
            DV_DIV:
            begin
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                rem_reg <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == DV_FIX);

    always_comb
    begin
        big     = |quo_reg[NUM_W-1:RPM_W];
        q32     = quo_reg[RPM_W-1:0];
        over    = 1'b0;
        mag_out = q32;
        rpm     = q32;
        sat     = 1'b0;
        if (den_zero_reg)
        begin
            sat = 1'b1;
            if (mag_reg == '0)
            begin
                rpm = '0;
            end
            else if (neg_reg)
            begin
                rpm = RPM_MIN;
            end
            else
            begin
                rpm = RPM_MAX;
            end
        end
        else if (neg_reg)
        begin
            over    = big || (q32[RPM_W-1] && (|q32[RPM_W-2:0]));
            mag_out = over ? RPM_MIN : q32;
            rpm     = -mag_out;
            sat     = over;
        end
        else
        begin
            over = big || q32[RPM_W-1];
            rpm  = over ? RPM_MAX : q32;
            sat  = over;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder speed estimator testbench
// Streams encoder readings through the estimator under random idling and one
// long output hold-off, predicts each RPM result alongside the block, and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ese_pkg::*;

    localparam int          WIN_DEPTH      = 64;
    localparam logic [63:0] NS_PER_MIN_Q8  = 64'd15360000000000;
    localparam int          SETTLE_CYCLES  = 300;
    localparam int          HOLD_CYCLES    = 3000;
    localparam int          HOLD_AT_RESULT = 400;
    localparam int          TIMEOUT_NS     = 20_000_000;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             sat;
    } speed_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // [11:0] position, [75:12] timestamp_ns
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [31:0] rpm_value, [32] saturated

    encoder_speed_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [POS_W-1:0] est_last_pos   = '0;
    logic [TS_W-1:0]  est_last_ts    = '0;
    logic             est_primed     = 1'b0;
    int               win_step [WIN_DEPTH];
    logic [TS_W-1:0]  win_delta [WIN_DEPTH];
    longint           est_step_sum   = 0;
    logic [TS_W-1:0]  est_delta_sum  = '0;
    int               est_fill       = 0;
    int               est_slot       = 0;
    logic             est_avg_en     = 1'b0;
    logic [CFG_W-1:0] est_win_len    = WIN_LEN_RESET;

    speed_t           speed_expect_q[$];
    logic [IN_DATA_W-1:0] pending_items[$];

    int               items_queued   = 0;
    int               items_accepted = 0;
    int               results_seen   = 0;
    int               mismatches     = 0;
    int               cycle_count    = 0;
    int               hold_left      = 0;
    logic             hold_done      = 1'b0;
    logic [POS_W-1:0] gen_pos        = '0;
    logic [TS_W-1:0]  gen_ts         = '0;
    speed_t           want;

    // long stretches with no idling on either side
    wire steady = (cycle_count % 40000) >= 30000;

    function automatic int wrap_step(input int now_p, input int prev_p);
        int d;
        int a;
        d = now_p - prev_p;
        a = (d < 0) ? -d : d;
        if (a < POS_RANGE - a)
            return d;
        return (prev_p < now_p) ? -(POS_RANGE - a) : (POS_RANGE - a);
    endfunction

    function automatic speed_t rpm_q8(input longint steps, input logic [TS_W-1:0] elapsed);
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        speed_t       r;
        mag = (steps < 0) ? 64'(-steps) : 64'(steps);
        num = 128'(mag) * 128'(NS_PER_MIN_Q8);
        den = 128'(elapsed) * 128'(POS_RANGE);
        r.sat = 1'b0;
        if (den == 0)
        begin
            r.sat = 1'b1;
            if (mag == 0)
                r.rpm = '0;
            else
                r.rpm = (steps < 0) ? RPM_MIN : RPM_MAX;
        end
        else
        begin
            quo = num / den;
            if (steps < 0)
            begin
                if (quo > 128'h8000_0000)
                begin
                    r.sat = 1'b1;
                    quo   = 128'h8000_0000;
                end
                r.rpm = 32'd0 - quo[31:0];
            end
            else
            begin
                if (quo > 128'h7FFF_FFFF)
                begin
                    r.sat = 1'b1;
                    quo   = 128'h7FFF_FFFF;
                end
                r.rpm = quo[31:0];
            end
        end
        return r;
    endfunction

    function automatic void predict_speed(input logic [POS_W-1:0] pos,
                                          input logic [TS_W-1:0] ts);
        int              step;
        int              len;
        int              oldest;
        logic [TS_W-1:0] elapsed;
        if (!est_primed)
        begin
            est_last_pos = pos;
            est_last_ts  = ts;
            est_primed   = 1'b1;
            return;
        end
        step         = wrap_step(int'(pos), int'(est_last_pos));
        elapsed      = ts - est_last_ts;
        est_last_pos = pos;
        est_last_ts  = ts;
        len = int'(est_win_len);
        if (len < 1)
            len = 1;
        if (len > WIN_DEPTH)
            len = WIN_DEPTH;
        while (est_fill >= len)
        begin
            oldest        = (est_slot + WIN_DEPTH - est_fill) % WIN_DEPTH;
            est_step_sum  -= win_step[oldest];
            est_delta_sum -= win_delta[oldest];
            est_fill--;
        end
        win_step[est_slot]  = step;
        win_delta[est_slot] = elapsed;
        est_step_sum  += step;
        est_delta_sum += elapsed;
        est_fill++;
        est_slot = (est_slot + 1) % WIN_DEPTH;
        if (est_avg_en)
            speed_expect_q.push_back(rpm_q8(est_step_sum, est_delta_sum));
        else
            speed_expect_q.push_back(rpm_q8(step, elapsed));
    endfunction

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // input side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_speed(s_tdata[POS_W-1:0], s_tdata[POS_W +: TS_W]);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 29))
                begin
                    s_tdata  <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (speed_expect_q.size() == 0)
            begin
                $display("%0t: result with none expected: rpm=%h sat=%b",
                         $time, m_tdata[RPM_W-1:0], m_tdata[RPM_W]);
                mismatches++;
            end
            else
            begin
                want = speed_expect_q.pop_front();
                if (m_tdata[RPM_W-1:0] !== want.rpm)
                begin
                    $display("%0t: rpm_value expected %h actual %h",
                             $time, want.rpm, m_tdata[RPM_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[RPM_W] !== want.sat)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, m_tdata[RPM_W]);
                    mismatches++;
                end
            end
        end
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT_RESULT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_AVERAGE_ENABLE)
            est_avg_en = val[0];
        else
            est_win_len = val;
    endtask

    task automatic set_config(input logic avg, input logic [CFG_W-1:0] len);
        write_reg(REG_AVERAGE_ENABLE, {6'($urandom), avg});
        write_reg(REG_WINDOW_LENGTH, len);
    endtask

    task automatic queue_reading(input logic [POS_W-1:0] pos, input logic [TS_W-1:0] ts);
        pending_items.push_back(IN_DATA_W'({ts, pos}));
        items_queued++;
        gen_pos = pos;
        gen_ts  = ts;
    endtask

    task automatic settle();
        while (items_accepted != items_queued || speed_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly plausible motion, with wrap ties, position jumps and time jumps
    task automatic random_run(input int count);
        int               roll;
        int               step;
        logic [POS_W-1:0] pos;
        logic [TS_W-1:0]  delta;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                step = 0;
            else if (roll < 50)
                step = $urandom_range(64);
            else if (roll < 80)
                step = $urandom_range(2047);
            else
                step = POS_RANGE / 2;
            if ($urandom_range(1))
                step = -step;
            if (roll < 90)
                pos = POS_W'(int'(gen_pos) + step);
            else
                pos = POS_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 5)
                delta = '0;
            else if (roll < 15)
                delta = TS_W'($urandom_range(16, 1));
            else if (roll < 55)
                delta = TS_W'($urandom_range(100000, 1));
            else if (roll < 85)
                delta = {32'd0, $urandom};
            else if (roll < 95)
                delta = {24'd0, 8'($urandom), $urandom};
            else
                delta = {$urandom, $urandom};
            queue_reading(pos, gen_ts + delta);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed readings under reset configuration
        queue_reading(12'd4095, 64'd100);                  // priming only
        queue_reading(12'd4095, 64'd100);                  // no motion, no time
        queue_reading(12'd0,    64'd100);                  // +1 across wrap, no time
        queue_reading(12'd4095, 64'd100);                  // -1 across wrap, no time
        queue_reading(12'd0,    64'd1100);
        queue_reading(12'd2048, 64'd2100);                 // half turn, moving up
        queue_reading(12'd0,    64'd3100);                 // half turn, moving down
        queue_reading(12'd2047, 64'd3101);                 // clips high
        queue_reading(12'd0,    64'd3102);                 // clips low
        queue_reading(12'd0,    64'd2000);                 // time runs backwards
        queue_reading(12'd5,    64'd1000);
        queue_reading(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_reading(12'd0,    64'd0);
        queue_reading(12'd1,    64'd3750000000);           // exactly one LSB
        queue_reading(12'd0,    64'd7500000000);           // exactly minus one LSB
        queue_reading(12'd2048, 64'h8000_0000_0000_0000);
        queue_reading(12'd2049, 64'h8000_0000_0000_0001);
        queue_reading(12'd1000, 64'h8000_0000_0001_0000);
        queue_reading(12'd3000, 64'h8000_0000_0001_0003);
        settle();

        set_config(1'b1, 7'd64);
        random_run(300);
        settle();
        set_config(1'b1, 7'd1);                            // window collapses at once
        random_run(100);
        settle();
        set_config(1'b1, 7'd0);
        random_run(100);
        settle();
        set_config(1'b0, 7'd127);
        random_run(250);
        settle();
        set_config(1'b1, 7'd127);
        random_run(250);
        settle();
        set_config(1'b0, CFG_W'($urandom_range(64, 1)));
        random_run(200);
        settle();
        set_config(1'b1, 7'd2);
        random_run(150);
        settle();
        set_config(1'b1, CFG_W'($urandom_range(64, 1)));
        random_run(250);
        settle();

        if (speed_expect_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, speed_expect_q.size());
        if (mismatches == 0 && speed_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
